### rtl/cwt_pkg.sv
// ----------------------------------------------------------------------------
// cwt_pkg
// Shared types, register codes and arithmetic helpers for the crease warp.
// ----------------------------------------------------------------------------
package cwt_pkg;

  localparam int MAX_SLOTS          = 6;
  localparam int DEF_CREASE_SLOTS   = 6;
  localparam int DEF_COSINE_DEPTH   = 256;
  localparam int CFG_IDX_W          = 3;
  localparam int CFG_DATA_W         = 64;

  localparam logic [CFG_IDX_W-1:0] REG_CURVE_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE_MASK = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CREASE_0    = 3'd2;

  localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam logic signed [31:0] ONE_Q16 = 32'sd65536;

  typedef enum logic [1:0] {
    CURVE_LINEAR  = 2'd0,
    CURVE_SMOOTH  = 2'd1,
    CURVE_COSINE  = 2'd2,
    CURVE_HERMITE = 2'd3
  } curve_t;

  // one sample travelling down the slot chain
  typedef struct packed {
    logic               vld;
    logic               last;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] slope;
  } lane_t;

  // falloff value K and the magnitude of dK/dt, both Q.16
  typedef struct packed {
    logic [16:0] k;
    logic [16:0] dkm;
  } fall_t;

  // round half away from zero, shift right by s
  function automatic logic signed [63:0] rnd_haz(input logic signed [63:0] v,
                                                 input int unsigned s);
    logic [63:0] m;
    begin
      m = v[63] ? 64'(-v) : 64'(v);
      m = (m + (64'd1 << (s - 1))) >> s;
      rnd_haz = v[63] ? -$signed(m) : $signed(m);
    end
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    begin
      if (v > 64'sd2147483647) sat32 = 32'sh7FFF_FFFF;
      else if (v < -64'sd2147483648) sat32 = 32'sh8000_0000;
      else sat32 = v[31:0];
    end
  endfunction

  // raised-cosine entry from phase u (Q.30, folded); returns {K, |dK/dt|}
  function automatic logic [33:0] cos_entry(input logic [63:0] u, input logic upper);
    logic [63:0] v, c, s, sub, k30, m;
    begin
      v = (u * u) >> 30;
      c = ONE_Q30;
      sub = ((v * c) >> 30) / 90;  c = (sub > ONE_Q30) ? 64'd0 : ONE_Q30 - sub;
      sub = ((v * c) >> 30) / 56;  c = (sub > ONE_Q30) ? 64'd0 : ONE_Q30 - sub;
      sub = ((v * c) >> 30) / 30;  c = (sub > ONE_Q30) ? 64'd0 : ONE_Q30 - sub;
      sub = ((v * c) >> 30) / 12;  c = (sub > ONE_Q30) ? 64'd0 : ONE_Q30 - sub;
      sub = ((v * c) >> 30) / 2;   c = (sub > ONE_Q30) ? 64'd0 : ONE_Q30 - sub;
      s = ONE_Q30;
      sub = ((v * s) >> 30) / 110; s = (sub > ONE_Q30) ? 64'd0 : ONE_Q30 - sub;
      sub = ((v * s) >> 30) / 72;  s = (sub > ONE_Q30) ? 64'd0 : ONE_Q30 - sub;
      sub = ((v * s) >> 30) / 42;  s = (sub > ONE_Q30) ? 64'd0 : ONE_Q30 - sub;
      sub = ((v * s) >> 30) / 20;  s = (sub > ONE_Q30) ? 64'd0 : ONE_Q30 - sub;
      sub = ((v * s) >> 30) / 6;   s = (sub > ONE_Q30) ? 64'd0 : ONE_Q30 - sub;
      s = (u * s) >> 30;
      k30 = upper ? (ONE_Q30 - c) / 2 : (ONE_Q30 + c) / 2;
      m = (PI_Q30 * s) >> 31;
      cos_entry = {17'((k30 + 64'd8192) >> 14), 17'((m + 64'd8192) >> 14)};
    end
  endfunction

endpackage

### rtl/cwt_if.sv
// ----------------------------------------------------------------------------
// cwt_in_if / cwt_out_if
// Valid/ready channels for samples and warp results.
// ----------------------------------------------------------------------------
interface cwt_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sample_in;
  logic               sample_last;
  modport source(output valid, sample_in, sample_last, input ready);
  modport sink(input valid, sample_in, sample_last, output ready);
endinterface

interface cwt_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] warped_out;
  logic signed [31:0] delta_out;
  logic signed [31:0] slope_out;
  logic               result_last;
  modport source(output valid, warped_out, delta_out, slope_out, result_last, input ready);
  modport sink(input valid, warped_out, delta_out, slope_out, result_last, output ready);
endinterface

### rtl/cwt_falloff.sv
// ----------------------------------------------------------------------------
// cwt_falloff
// Four-stage falloff unit: K(t) and |dK/dt| for the selected curve.
// ----------------------------------------------------------------------------
module cwt_falloff #(
  parameter int COSINE_TABLE_DEPTH = cwt_pkg::DEF_COSINE_DEPTH
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [1:0]           curve_mode,
  input  logic [15:0]          t,
  output cwt_pkg::fall_t       fall
);
  import cwt_pkg::*;

  localparam int NW  = $clog2(COSINE_TABLE_DEPTH + 1);
  localparam int NPW = 16 + NW + 1;
  localparam logic [NPW-1:0] DEP = NPW'(COSINE_TABLE_DEPTH);

  logic [33:0] cos_rom [COSINE_TABLE_DEPTH+1];

  for (genvar g = 0; g <= COSINE_TABLE_DEPTH; g++) begin : g_rom
    localparam int unsigned R = (2 * g > COSINE_TABLE_DEPTH) ? COSINE_TABLE_DEPTH - g : g;
    localparam logic [63:0] U = (PI_Q30 * 64'(R)) / COSINE_TABLE_DEPTH;
    assign cos_rom[g] = cos_entry(U, 2 * g > COSINE_TABLE_DEPTH);
  end

  // stage 1
  logic [15:0] t1;
  logic [31:0] t2_1;
  logic [30:0] u1;
  logic [NW-1:0] n1;
  logic [NPW-1:0] nprod;
  logic [32:0] uprod;
  // stage 2
  logic [15:0] t2r;
  logic [31:0] t2_2;
  logic [47:0] t3_2;
  logic [14:0] u16_2;
  logic [19:0] q16_2;
  logic [16:0] sdk_2;
  logic [33:0] cos_2;
  logic [35:0] q;
  logic [33:0] sdk_w;
  // stage 3
  logic [15:0] t3r;
  logic [16:0] ks_3;
  logic [32:0] c_3;
  logic [19:0] q16_3;
  logic [29:0] u16sq_3;
  logic [16:0] sdk_3;
  logic [33:0] cos_3;
  logic [49:0] p_s;
  logic [17:0] ps_r;
  // stage 4
  logic [52:0] hprod;
  logic [20:0] hp;
  logic [34:0] hdk_w;
  fall_t fall_next;

  always_comb begin
    nprod = NPW'(t) * DEP + NPW'(32768);
    uprod = 33'(t) * (33'd65536 - 33'(t));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1   <= t;
      t2_1 <= 32'(t) * 32'(t);
      u1   <= uprod[30:0];
      n1   <= NW'(nprod >> 16);
    end
  end

  always_comb begin
    q = 36'(t2_1) * 36'd6 + (36'd10 << 32) - 36'({t1, 16'd0}) * 36'd15;
    sdk_w = 34'(u1) * 34'd6 + 34'd32768;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t2r   <= t1;
      t2_2  <= t2_1;
      t3_2  <= 48'(t2_1) * 48'(t1);
      u16_2 <= 15'((32'(u1) + 32'd32768) >> 16);
      q16_2 <= 20'((q + 36'd32768) >> 16);
      sdk_2 <= 17'(sdk_w >> 16);
      cos_2 <= cos_rom[n1];
    end
  end

  always_comb begin
    p_s  = (50'(t2_2) * 50'd3 << 16) - 50'(t3_2) * 50'd2;
    ps_r = 18'((p_s + (50'd1 << 31)) >> 32);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t3r     <= t2r;
      ks_3    <= 17'(18'd65536 - ps_r);
      c_3     <= 33'((t3_2 + 48'd32768) >> 16);
      q16_3   <= q16_2;
      u16sq_3 <= 30'(u16_2) * 30'(u16_2);
      sdk_3   <= sdk_2;
      cos_3   <= cos_2;
    end
  end

  always_comb begin
    hprod = 53'(c_3) * 53'(q16_3);
    hp    = 21'((hprod + (53'd1 << 31)) >> 32);
    hdk_w = 35'(u16sq_3) * 35'd30 + 35'd32768;
    unique case (curve_t'(curve_mode))
      CURVE_LINEAR: begin
        fall_next.k   = 17'(17'd65536 - 17'(t3r));
        fall_next.dkm = 17'd65536;
      end
      CURVE_SMOOTH: begin
        fall_next.k   = ks_3;
        fall_next.dkm = sdk_3;
      end
      CURVE_COSINE: begin
        fall_next.k   = cos_3[33:17];
        fall_next.dkm = cos_3[16:0];
      end
      default: begin
        fall_next.k   = (hp > 21'd65536) ? 17'd0 : 17'(21'd65536 - hp);
        fall_next.dkm = 17'(hdk_w >> 16);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fall <= fall_next;
    end
  end

endmodule

### rtl/cwt_slot.sv
// ----------------------------------------------------------------------------
// cwt_slot
// One crease slot: nine pipeline stages from distance to updated slope.
// ----------------------------------------------------------------------------
module cwt_slot #(
  parameter int COSINE_TABLE_DEPTH = cwt_pkg::DEF_COSINE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 slot_on,
  input  logic [1:0]           curve_mode,
  input  logic [63:0]          crease_word,
  input  cwt_pkg::lane_t       lane_in,
  output cwt_pkg::lane_t       lane_out
);
  import cwt_pkg::*;

  localparam int FALL_LAT = 4;

  typedef struct packed {
    lane_t              ln;
    logic               hit;
    logic signed [32:0] diff;
    logic [32:0]        absd;
    logic [23:0]        tq;
    logic [16:0]        k;
    logic signed [18:0] gk;
    logic [17:0]        a;
    logic signed [21:0] l;
  } sd_t;

  logic signed [31:0] pos;
  logic [15:0]        invr;
  logic signed [15:0] gain;

  sd_t p1, p2, p5, p6;
  sd_t p1_next, p2_next, p5_next, p6_next;
  lane_t lane_next;
  sd_t dly [FALL_LAT];
  fall_t fall;

  logic signed [32:0] diff_w;
  logic [48:0]        tq_w;
  logic signed [33:0] gk_w;
  logic [40:0]        a_w;
  logic signed [18:0] am_w;
  logic signed [34:0] g2_w;
  logic signed [51:0] dy_w;
  logic signed [53:0] sl_w;
  logic signed [63:0] y_w;

  assign pos  = crease_word[31:0];
  assign invr = crease_word[47:32];
  assign gain = crease_word[63:48];

  assign diff_w = {pos[31], pos} - {lane_in.y[31], lane_in.y};
  assign tq_w   = 49'(p1.absd) * 49'(invr);

  always_comb begin
    p1_next      = '0;
    p1_next.ln   = lane_in;
    p1_next.diff = diff_w;
    p1_next.absd = diff_w[32] ? 33'(-diff_w) : 33'(diff_w);
    p2_next      = p1;
    p2_next.hit  = slot_on && (tq_w < 49'(1 << 24));
    p2_next.tq   = tq_w[23:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1.ln.vld <= 1'b0;
      p2.ln.vld <= 1'b0;
    end else if (en) begin
      p1 <= p1_next;
      p2 <= p2_next;
    end
  end

  cwt_falloff #(.COSINE_TABLE_DEPTH(COSINE_TABLE_DEPTH)) u_fall (
    .clk        (clk),
    .en         (en),
    .curve_mode (curve_mode),
    .t          (p2.tq[23:8]),
    .fall       (fall)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < FALL_LAT; i++) dly[i].ln.vld <= 1'b0;
    end else if (en) begin
      dly[0] <= p2;
      for (int i = 1; i < FALL_LAT; i++) dly[i] <= dly[i-1];
    end
  end

  always_comb begin
    gk_w = gain * $signed({1'b0, fall.k});
    a_w  = 41'(fall.dkm) * 41'(dly[FALL_LAT-1].tq) + (41'd1 << 23);
    am_w = $signed({1'b0, p5.a}) - $signed({2'b0, p5.k});
    g2_w = gain * am_w;
    dy_w = p5.gk * p5.diff;
    y_w  = 64'(p5.ln.y) + rnd_haz(64'(dy_w), 16);
    sl_w = p6.ln.slope * p6.l;

    p5_next    = dly[FALL_LAT-1];
    p5_next.k  = fall.k;
    p5_next.gk = 19'(rnd_haz(64'(gk_w), 14));
    p5_next.a  = 18'(a_w >> 24);
    p6_next    = p5;
    p6_next.l  = 22'(64'sd65536 + rnd_haz(64'(g2_w), 14));
    if (p5.hit) p6_next.ln.y = sat32(y_w);
    lane_next = p6.ln;
    if (p6.hit) lane_next.slope = sat32(rnd_haz(64'(sl_w), 16));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p5.ln.vld <= 1'b0;
      p6.ln.vld <= 1'b0;
      lane_out.vld <= 1'b0;
    end else if (en) begin
      p5       <= p5_next;
      p6       <= p6_next;
      lane_out <= lane_next;
    end
  end

endmodule

### rtl/crease_warp_transfer_unit.sv
// ----------------------------------------------------------------------------
// crease_warp_transfer_unit
// Warps a Q16.16 sample through up to six creases and tracks dy/dx.
// ----------------------------------------------------------------------------
// Samples enter on in_ch and results leave on out_ch, both valid/ready; a
// transaction completes when valid and ready are high at a clock edge.
// Configuration is written through cfg_we/cfg_index/cfg_data while idle:
// index 0 curve mode, 1 enable mask, 2..7 crease words for slots 0..5.
// The pipe is one input register, nine stages per slot (distance,
// distance product, four stages of falloff, gain products, value update,
// slope update) and one output register. One sample is taken per cycle
// while out_ch is taking results. All stages share one advance enable;
// when out_ch stalls with a result held, the whole pipe and in_ch.ready
// hold with it, nothing is lost.
// Synchronous reset empties the pipe and sets curve mode to smoothstep,
// the enable mask and crease words to zero.
// ----------------------------------------------------------------------------
module crease_warp_transfer_unit #(
  parameter int CREASE_SLOTS       = cwt_pkg::DEF_CREASE_SLOTS,
  parameter int COSINE_TABLE_DEPTH = cwt_pkg::DEF_COSINE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  cwt_in_if.sink                            in_ch,
  cwt_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [cwt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cwt_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import cwt_pkg::*;

  logic [1:0]  curve_mode;
  logic [5:0]  enable_mask;
  logic [63:0] crease_word [MAX_SLOTS];

  logic  en;
  lane_t lanes [CREASE_SLOTS+1];
  logic  out_vld;
  logic signed [32:0] delta_w;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      curve_mode  <= CURVE_SMOOTH;
      enable_mask <= '0;
      for (int i = 0; i < MAX_SLOTS; i++) crease_word[i] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CURVE_MODE:  curve_mode  <= cfg_data[1:0];
        REG_ENABLE_MASK: enable_mask <= cfg_data[5:0];
        default: begin
          if (cfg_index >= REG_CREASE_0)
            crease_word[3'(cfg_index - REG_CREASE_0)] <= cfg_data;
        end
      endcase
    end
  end

  assign en          = !out_vld || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      lanes[0].vld <= 1'b0;
    end else if (en) begin
      lanes[0].vld   <= in_ch.valid;
      lanes[0].last  <= in_ch.sample_last;
      lanes[0].x     <= in_ch.sample_in;
      lanes[0].y     <= in_ch.sample_in;
      lanes[0].slope <= ONE_Q16;
    end
  end

  for (genvar g = 0; g < CREASE_SLOTS; g++) begin : g_slot
    cwt_slot #(.COSINE_TABLE_DEPTH(COSINE_TABLE_DEPTH)) u_slot (
      .clk         (clk),
      .rst         (rst),
      .en          (en),
      .slot_on     (enable_mask[g]),
      .curve_mode  (curve_mode),
      .crease_word (crease_word[g]),
      .lane_in     (lanes[g]),
      .lane_out    (lanes[g+1])
    );
  end

  assign delta_w = {lanes[CREASE_SLOTS].y[31], lanes[CREASE_SLOTS].y}
                 - {lanes[CREASE_SLOTS].x[31], lanes[CREASE_SLOTS].x};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld            <= lanes[CREASE_SLOTS].vld;
      out_ch.warped_out  <= lanes[CREASE_SLOTS].y;
      out_ch.delta_out   <= sat32(64'(delta_w));
      out_ch.slope_out   <= lanes[CREASE_SLOTS].slope;
      out_ch.result_last <= lanes[CREASE_SLOTS].last;
    end
  end

  assign out_ch.valid = out_vld;

  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !out_ch.valid)
    else $error("result presented straight after reset");

  a_hold_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ch.ready |-> (out_ch.valid && !out_ch.ready))
    else $error("input held off without a stalled result");

endmodule

### verif/crease_warp_transfer_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// crease_warp_transfer_unit_tb
// Drives samples through the crease warp under several curve and slot
// settings, predicts warped value, delta and slope for every transaction,
// and compares each result in order while both channels stall at random.
// ----------------------------------------------------------------------------
module crease_warp_transfer_unit_tb;
  import cwt_pkg::*;

  localparam int PIPE_DEPTH   = 2 + 9 * MAX_SLOTS;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RAND_PHASES  = 19;
  localparam int PHASE_ITEMS  = 40;

  typedef struct {
    logic signed [31:0] warped;
    logic signed [31:0] delta;
    logic signed [31:0] slope;
    logic               last;
  } warp_t;

  typedef struct {
    int                 setup;
    logic signed [31:0] x;
    logic               last;
    logic               typed;
    warp_t              want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  cwt_in_if  in_ch();
  cwt_out_if out_ch();

  crease_warp_transfer_unit DUT (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  curve_t      curve_reg;
  logic [5:0]  mask_reg;
  logic [63:0] crease_reg [MAX_SLOTS];

  warp_t pending_q [$];
  int    fail_count = 0;
  int    cycle_count = 0;
  int    send_idle = 0;
  int    recv_idle = 0;

  // ---- predictor ----------------------------------------------------------
  function automatic longint round_off(longint v, int s);
    longint unsigned m;
    m = (v < 0) ? longint'(-v) : v;
    m = (m + (64'd1 << (s - 1))) >> s;
    return (v < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned taper(longint unsigned v, longint unsigned a,
                                            longint unsigned d);
    longint unsigned sub;
    sub = ((v * a) >> 30) / d;
    return (sub > ONE_Q30) ? 64'd0 : ONE_Q30 - sub;
  endfunction

  function automatic void cosine_point(longint unsigned n, output longint k,
                                       output longint dk);
    logic upper;
    longint unsigned r, u, v, c, s, k30, m;
    upper = (2 * n) > 256;
    r = upper ? 256 - n : n;
    u = (PI_Q30 * r) / 256;
    v = (u * u) >> 30;
    c = ONE_Q30;
    c = taper(v, c, 90); c = taper(v, c, 56); c = taper(v, c, 30);
    c = taper(v, c, 12); c = taper(v, c, 2);
    s = ONE_Q30;
    s = taper(v, s, 110); s = taper(v, s, 72); s = taper(v, s, 42);
    s = taper(v, s, 20); s = taper(v, s, 6);
    s = (u * s) >> 30;
    k30 = upper ? (ONE_Q30 - c) / 2 : (ONE_Q30 + c) / 2;
    m = (PI_Q30 * s) >> 31;
    k = longint'((k30 + 64'd8192) >> 14);
    dk = -longint'((m + 64'd8192) >> 14);
  endfunction

  function automatic void falloff_of(curve_t mode, longint unsigned t,
                                     output longint k, output longint dk);
    longint unsigned u, p, q, q16, c, u16;
    u = t * (64'd65536 - t);
    case (mode)
      CURVE_LINEAR: begin
        k = 65536 - longint'(t);
        dk = -65536;
      end
      CURVE_SMOOTH: begin
        p = 64'd3 * t * t * 64'd65536 - 64'd2 * t * t * t;
        k = 65536 - longint'((p + (64'd1 << 31)) >> 32);
        dk = -longint'((64'd6 * u + 64'd32768) >> 16);
      end
      CURVE_COSINE: begin
        cosine_point((t * 64'd256 + 64'd32768) >> 16, k, dk);
      end
      default: begin
        q = 64'd6 * t * t + 64'd10 * (64'd1 << 32) - 64'd15 * t * 64'd65536;
        q16 = (q + 64'd32768) >> 16;
        c = (t * t * t + 64'd32768) >> 16;
        p = (c * q16 + (64'd1 << 31)) >> 32;
        u16 = (u + 64'd32768) >> 16;
        k = (p > 64'd65536) ? 0 : 65536 - longint'(p);
        dk = -longint'((64'd30 * u16 * u16 + 64'd32768) >> 16);
      end
    endcase
  endfunction

  function automatic warp_t warp_predict(logic signed [31:0] sample, logic last);
    warp_t r;
    longint x, y, slope, pos, gain, diff, k, dk, gk, a, l;
    longint unsigned invr, absd, tq;
    x = sample;
    y = x;
    slope = 65536;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      if (mask_reg[i]) begin
        pos = longint'($signed(crease_reg[i][31:0]));
        invr = crease_reg[i][47:32];
        gain = longint'($signed(crease_reg[i][63:48]));
        diff = pos - y;
        absd = (diff < 0) ? longint'(-diff) : diff;
        tq = absd * invr;
        if (tq < (64'd1 << 24)) begin
          falloff_of(curve_reg, tq >> 8, k, dk);
          gk = round_off(gain * k, 14);
          a = round_off(-dk * longint'(tq), 24);
          l = 65536 + round_off(gain * (a - k), 14);
          slope = clamp32(round_off(slope * l, 16));
          y = clamp32(y + round_off(gk * diff, 16));
        end
      end
    end
    r.warped = y[31:0];
    r.delta = 32'(clamp32(y - x));
    r.slope = slope[31:0];
    r.last = last;
    return r;
  endfunction

  // ---- configuration ------------------------------------------------------
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      REG_CURVE_MODE:  curve_reg = curve_t'(value[1:0]);
      REG_ENABLE_MASK: mask_reg = value[5:0];
      default:         crease_reg[idx - REG_CREASE_0] = value;
    endcase
    @(negedge clk);
  endtask

  task automatic load_settings(logic [63:0] curve_word, logic [63:0] mask_word,
                               logic [63:0] words [MAX_SLOTS]);
    write_reg(REG_CURVE_MODE, curve_word);
    write_reg(REG_ENABLE_MASK, mask_word);
    for (int i = 0; i < MAX_SLOTS; i++)
      write_reg(REG_CREASE_0 + CFG_IDX_W'(i), words[i]);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  // ---- sample driver, called at a falling edge ----------------------------
  task automatic push_sample(logic signed [31:0] x, logic last, logic typed, warp_t want);
    if ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(99) < send_idle) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.sample_in <= x;
    in_ch.sample_last <= last;
    do @(posedge clk); while (!in_ch.ready);
    pending_q.insert(pending_q.size(), typed ? want : warp_predict(x, last));
    @(negedge clk);
  endtask

  // ---- receiver and checker -----------------------------------------------
  always @(negedge clk) begin
    if (!rst) out_ch.ready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    warp_t e;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_q.size() == 0) begin
        $error("result with no transaction outstanding: warped_out %0d", out_ch.warped_out);
        fail_count++;
      end else begin
        e = pending_q.pop_front();
        if (out_ch.warped_out !== e.warped) begin
          $error("warped_out expected %0d actual %0d", e.warped, out_ch.warped_out);
          fail_count++;
        end
        if (out_ch.delta_out !== e.delta) begin
          $error("delta_out expected %0d actual %0d", e.delta, out_ch.delta_out);
          fail_count++;
        end
        if (out_ch.slope_out !== e.slope) begin
          $error("slope_out expected %0d actual %0d", e.slope, out_ch.slope_out);
          fail_count++;
        end
        if (out_ch.result_last !== e.last) begin
          $error("result_last expected %0b actual %0b", e.last, out_ch.result_last);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---- directed table -----------------------------------------------------
  function automatic warp_t same(logic signed [31:0] x, logic last);
    warp_t r;
    r.warped = x;
    r.delta = 0;
    r.slope = ONE_Q16;
    r.last = last;
    return r;
  endfunction

  function automatic row_t mk(int setup, logic signed [31:0] x, logic last, logic typed);
    row_t r;
    r.setup = setup;
    r.x = x;
    r.last = last;
    r.typed = typed;
    r.want = same(x, last);
    return r;
  endfunction

  // ---- random stimulus helpers --------------------------------------------
  function automatic logic [63:0] random_word(int phase);
    logic [31:0] pos;
    logic [15:0] invr, gain;
    case ($urandom_range(3))
      0: pos = $urandom();
      default: pos = 32'($signed($urandom_range(400 << 16)) - (200 << 16));
    endcase
    case ($urandom_range(4))
      0: invr = 16'd0;
      1: invr = 16'($urandom());
      default: invr = 16'($urandom_range(1, 4096));
    endcase
    gain = 16'($urandom());
    if (phase == 2) return 64'hFFFF_FFFF_FFFF_FFFF;
    if (phase == 3) return {16'h7FFF, 16'd1, 32'h7FFF_FFFF};
    if (phase == 4) return {16'h8000, 16'hFFFF, 32'h8000_0000};
    return {gain, invr, pos};
  endfunction

  function automatic logic signed [31:0] random_sample;
    int slot;
    longint unsigned reach;
    longint offset;
    slot = $urandom_range(MAX_SLOTS - 1);
    case ($urandom_range(19))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2, 3, 4: return $urandom();
      default: begin
        reach = (crease_reg[slot][47:32] == 0) ? 64'd1 << 20
                : (64'd1 << 24) / crease_reg[slot][47:32];
        offset = longint'($urandom_range(32'(2 * reach))) - longint'(reach);
        return 32'(longint'($signed(crease_reg[slot][31:0])) + offset);
      end
    endcase
  endfunction

  // ---- main sequence ------------------------------------------------------
  initial begin
    row_t rows [$];
    logic [63:0] words [MAX_SLOTS];
    logic [63:0] curve_word, mask_word;
    int setup_now;
    warp_t none;

    in_ch.valid = 1'b0;
    in_ch.sample_in = '0;
    in_ch.sample_last = 1'b0;
    out_ch.ready = 1'b0;
    curve_reg = CURVE_SMOOTH;
    mask_reg = '0;
    for (int i = 0; i < MAX_SLOTS; i++) crease_reg[i] = '0;
    none = same(0, 0);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_idle = 37;
    recv_idle = 86;

    // after reset every slot is off: samples pass straight through
    rows.insert(rows.size(), mk(0, 32'sd0, 1'b0, 1'b1));
    rows.insert(rows.size(), mk(0, 32'sh7FFF_FFFF, 1'b1, 1'b1));
    rows.insert(rows.size(), mk(0, 32'sh8000_0000, 1'b0, 1'b1));
    rows.insert(rows.size(), mk(0, 32'sd1, 1'b1, 1'b1));
    rows.insert(rows.size(), mk(0, -32'sd1, 1'b0, 1'b1));
    for (int c = 1; c <= 4; c++) begin
      rows.insert(rows.size(), mk(c, 32'sh0000_8000, 1'b0, 1'b0));
      rows.insert(rows.size(), mk(c, -32'sh0000_4000, 1'b1, 1'b0));
      rows.insert(rows.size(), mk(c, 32'sh0001_0000, 1'b0, 1'b0));
      rows.insert(rows.size(), mk(c, 32'sh7FFF_0000, 1'b1, 1'b0));
    end

    setup_now = 0;
    foreach (rows[r]) begin
      if (rows[r].setup != setup_now) begin
        setup_now = rows[r].setup;
        in_ch.valid <= 1'b0;
        drain();
        // unit radius at the origin, zero inverse radius with negative gain,
        // full-gain slot at the top of the range, slot 5 on, 3 and 4 off
        words[0] = {16'h4000, 16'h0100, 32'h0000_0000};
        words[1] = {16'hE000, 16'h0000, 32'h0000_4000};
        words[2] = {16'h7FFF, 16'h0001, 32'h7FFF_FFFF};
        words[3] = 64'hFFFF_FFFF_FFFF_FFFF;
        words[4] = 64'h0;
        words[5] = {16'h2000, 16'h0200, 32'hFFFF_8000};
        curve_word = {62'h3FFF_FFFF_FFFF_FFFF, 2'(setup_now - 1)};
        load_settings(curve_word, 64'hFFFF_FFFF_FFFF_FFE7, words);
      end
      push_sample(rows[r].x, rows[r].last, rows[r].typed, rows[r].want);
    end

    for (int p = 0; p < RAND_PHASES; p++) begin
      if (p == RAND_PHASES / 3) begin
        send_idle = 86;
        recv_idle = 37;
      end else if (p == 2 * RAND_PHASES / 3) begin
        send_idle = 0;
        recv_idle = 0;
      end
      in_ch.valid <= 1'b0;
      drain();
      for (int i = 0; i < MAX_SLOTS; i++) words[i] = random_word(p);
      curve_word = {$urandom(), $urandom()};
      if ($urandom_range(1)) curve_word[63:2] = '0;
      mask_word = (p == 0 || p >= 2 && p <= 4) ? 64'd63 : (p == 1) ? 64'd0
                  : {$urandom(), $urandom()};
      load_settings(curve_word, mask_word, words);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 5 && n == PHASE_ITEMS / 2) begin
          in_ch.valid <= 1'b0;
          @(negedge clk);
          while (pending_q.size() != 0) @(negedge clk);
        end
        push_sample(random_sample(), 1'($urandom()), 1'b0, none);
      end
    end
    in_ch.valid <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 8) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
